### hdl/btr_pkg.sv
// Shared types and constants of the block transfer reassembler.
`default_nettype none
package btr_pkg;

   localparam int unsigned WORD_W     = 16;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned NUM_WORDS  = 7;
   localparam int unsigned CSR_IDX_W  = 2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_INIT_CODE = 2'd0;
   localparam csr_idx_type CSR_CONT_CODE = 2'd1;
   localparam csr_idx_type CSR_CAPACITY  = 2'd2;

   localparam logic [WORD_W-1:0] INIT_CODE_RST = 16'hBBBB;
   localparam logic [WORD_W-1:0] CONT_CODE_RST = 16'h8888;
   localparam logic [WORD_W-1:0] CAPACITY_RST  = 16'hFFFF;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic open_block;
      logic clear_index;
      logic emit_byte;
      logic emit_done;
   } btr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_init;
      logic is_cont_open;
      logic at_len;
      logic at_cap;
      logic slot_free;
      logic byte_last;
   } btr_status_type;

endpackage
`default_nettype wire

### hdl/btr_if.sv
// Channel interfaces: packet input, byte write output and register write port.
`default_nettype none
interface btr_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] command;
   logic [15:0] word1;
   logic [15:0] word2;
   logic [15:0] word3;
   logic [15:0] word4;
   logic [15:0] word5;
   logic [15:0] word6;
   logic [15:0] word7;

   modport source (output valid, command, word1, word2, word3, word4, word5, word6, word7,
                   input ready);
   modport sink   (input valid, command, word1, word2, word3, word4, word5, word6, word7,
                   output ready);
endinterface

interface btr_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [15:0] write_address;
   logic [7:0]  write_data;
   logic        block_done;
   logic        last;

   modport source (output valid, write_enable, write_address, write_data, block_done, last,
                   input ready);
   modport sink   (input valid, write_enable, write_address, write_data, block_done, last,
                   output ready);
endinterface

interface btr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/btr_ctrl.sv
// Controller state machine: packet decode and per-byte sequencing.
`default_nettype none
module btr_ctrl
   import btr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire btr_status_type status,
   output btr_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.is_init) begin
               cmd.open_block = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.is_cont_open) begin
               if (status.at_len) begin
                  state_in = ST_DONE;
               end else if (status.at_cap) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.clear_index = 1'b1;
                  state_in        = ST_EMIT;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit_byte = 1'b1;
               if (status.byte_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DONE: begin
            if (status.slot_free) begin
               cmd.emit_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### hdl/btr_datapath.sv
// Datapath: registers, packet store, byte counter, byte select and result register.
`default_nettype none
module btr_datapath
   import btr_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = 14
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire btr_cmd_type         cmd,
   output btr_status_type           status,
   input  wire logic                csr_valid,
   input  wire csr_idx_type         csr_index,
   input  wire logic [WORD_W-1:0]   csr_data,
   input  wire logic [WORD_W-1:0]   req_command,
   input  wire logic [WORD_W-1:0]   req_words [NUM_WORDS],
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_write_enable,
   output logic [WORD_W-1:0]        rsp_write_address,
   output logic [BYTE_W-1:0]        rsp_write_data,
   output logic                     rsp_block_done,
   output logic                     rsp_last
);

   localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES);

   logic [WORD_W-1:0] init_code_ff, cont_code_ff, capacity_ff;
   logic [WORD_W-1:0] command_ff;
   logic [WORD_W-1:0] words_ff [NUM_WORDS];
   logic [WORD_W-1:0] len_ff, cnt_ff;
   logic              in_block_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic              valid_ff;
   logic              we_ff, done_ff, last_ff;
   logic [WORD_W-1:0] addr_ff;
   logic [BYTE_W-1:0] data_ff;

   logic [BYTE_W-1:0] byte_vec [PAYLOAD_BYTES];
   logic [WORD_W:0]   cnt_inc;
   logic              reach_len, reach_cap, idx_last;

   for (genvar j = 0; j < PAYLOAD_BYTES; j++) begin : g_bytes
      assign byte_vec[j] = words_ff[j / 2][(j % 2) * BYTE_W +: BYTE_W];
   end

   assign cnt_inc   = {1'b0, cnt_ff} + {{WORD_W{1'b0}}, 1'b1};
   assign reach_len = cnt_inc >= {1'b0, len_ff};
   assign reach_cap = cnt_inc >= {1'b0, capacity_ff};
   assign idx_last  = idx_ff == IDX_W'(PAYLOAD_BYTES - 1);

   always_comb begin
      status.is_init      = command_ff == init_code_ff;
      status.is_cont_open = (command_ff == cont_code_ff) && in_block_ff;
      status.at_len       = cnt_ff >= len_ff;
      status.at_cap       = cnt_ff >= capacity_ff;
      status.slot_free    = !valid_ff || rsp_ready;
      status.byte_last    = idx_last || reach_len || reach_cap;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_code_ff <= INIT_CODE_RST;
         cont_code_ff <= CONT_CODE_RST;
         capacity_ff  <= CAPACITY_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INIT_CODE: init_code_ff <= csr_data;
            CSR_CONT_CODE: cont_code_ff <= csr_data;
            CSR_CAPACITY:  capacity_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // packet store
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff <= req_command;
         words_ff   <= req_words;
      end
   end

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff <= 1'b0;
         len_ff      <= '0;
         cnt_ff      <= '0;
         idx_ff      <= '0;
      end else begin
         if (cmd.open_block) begin
            in_block_ff <= 1'b1;
            len_ff      <= words_ff[0];
            cnt_ff      <= '0;
         end
         if (cmd.clear_index) begin
            idx_ff <= '0;
         end
         if (cmd.emit_byte) begin
            cnt_ff <= cnt_inc[WORD_W-1:0];
            idx_ff <= idx_ff + IDX_W'(1);
            if (reach_len) begin
               in_block_ff <= 1'b0;
            end
         end
         if (cmd.emit_done) begin
            in_block_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit_byte || cmd.emit_done) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_byte) begin
         we_ff   <= 1'b1;
         addr_ff <= cnt_ff;
         data_ff <= byte_vec[idx_ff];
         done_ff <= reach_len;
         last_ff <= idx_last || reach_len || reach_cap;
      end else if (cmd.emit_done) begin
         we_ff   <= 1'b0;
         addr_ff <= '0;
         data_ff <= '0;
         done_ff <= 1'b1;
         last_ff <= 1'b1;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_write_data    = data_ff;
   assign rsp_block_done    = done_ff;
   assign rsp_last          = last_ff;

endmodule
`default_nettype wire

### hdl/block_transfer_reassembler_unit.sv
// Top level of the block transfer reassembler (receiver half).
// Each item is one eight-word link packet. An init packet (command equal to the
// init_code register) stores word1 as the declared block length, clears the byte
// count and opens a block; it gives no result. A continuation packet (command
// equal to cont_code) in an open block gives one byte write per payload byte, low
// byte of word1 first, at the running byte count, until the count reaches the
// declared length or the capacity register. The final result of a packet has last
// set, and block_done too when the block completed; a packet that completes the
// block without writing gives a single result with write_enable low. Any other
// packet is dropped. A packet is captured, then checked, then its results go out
// through the single byte lane that fills the result register one byte a cycle
// while the result slot is free; the next packet is taken once the last result of
// the current one is in the result register. Registers are written through the
// csr channel, which is always ready.
`default_nettype none
module block_transfer_reassembler_unit
   import btr_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   btr_req_if.sink   req_ch,
   btr_rsp_if.source rsp_ch,
   btr_csr_if.sink   csr_ch
);

   btr_cmd_type       cmd;
   btr_status_type    status;
   logic [WORD_W-1:0] req_words [NUM_WORDS];

   assign req_words[0] = req_ch.word1;
   assign req_words[1] = req_ch.word2;
   assign req_words[2] = req_ch.word3;
   assign req_words[3] = req_ch.word4;
   assign req_words[4] = req_ch.word5;
   assign req_words[5] = req_ch.word6;
   assign req_words[6] = req_ch.word7;

   assign csr_ch.ready = 1'b1;

   btr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   btr_datapath #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .req_command       (req_ch.command),
      .req_words         (req_words),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_write_enable  (rsp_ch.write_enable),
      .rsp_write_address (rsp_ch.write_address),
      .rsp_write_data    (rsp_ch.write_data),
      .rsp_block_done    (rsp_ch.block_done),
      .rsp_last          (rsp_ch.last)
   );

   a_nowrite_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.write_enable) |->
         (rsp_ch.block_done && rsp_ch.last && rsp_ch.write_address == '0))
      else $error("result without write is not a bare completion");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.block_done) |-> rsp_ch.last)
      else $error("block_done on a result that is not last");

   a_busy_mid_packet: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.last) |-> !req_ch.ready)
      else $error("new item taken before packet finished");

endmodule
`default_nettype wire

### verif/block_transfer_reassembler_unit_tb.sv
// Randomised self-checking testbench for the block transfer reassembler unit.
module block_transfer_reassembler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import btr_pkg::*;

   localparam int PAYLOAD_BYTES = 14;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_SHOWN     = 10;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 60;
   localparam csr_idx_type CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [15:0]      command;
      logic [6:0][15:0] words;
   } packet_type;

   typedef struct packed {
      logic        write_enable;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic        block_done;
      logic        last;
   } byte_write_type;

   class reassembly_scoreboard;
      logic [15:0] init_code, cont_code, capacity;
      logic [15:0] declared_len, byte_count;
      bit          block_open;
      byte_write_type expected_writes[$];
      int          mismatches, results_seen, packets_seen, blocks_done;

      function new();
         init_code    = INIT_CODE_RST;
         cont_code    = CONT_CODE_RST;
         capacity     = CAPACITY_RST;
         declared_len = '0;
         byte_count   = '0;
         block_open   = 1'b0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [15:0] value);
         case (idx)
            CSR_INIT_CODE: init_code = value;
            CSR_CONT_CODE: cont_code = value;
            CSR_CAPACITY:  capacity  = value;
            default: ;
         endcase
      endfunction

      function void note_packet(packet_type p);
         byte_write_type outs [PAYLOAD_BYTES];
         byte_write_type w;
         logic [15:0] word;
         int n;
         packets_seen++;
         if (p.command == init_code) begin
            declared_len = p.words[0];
            byte_count   = '0;
            block_open   = 1'b1;
            return;
         end
         if (p.command != cont_code || !block_open) return;
         n = 0;
         for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            if (byte_count >= declared_len || byte_count >= capacity) break;
            word            = p.words[k / 2];
            w.write_enable  = 1'b1;
            w.write_address = byte_count;
            w.write_data    = (k % 2 == 1) ? word[15:8] : word[7:0];
            w.block_done    = 1'b0;
            w.last          = 1'b0;
            outs[n]         = w;
            n++;
            byte_count++;
         end
         if (byte_count >= declared_len) begin
            block_open = 1'b0;
            blocks_done++;
            if (n == 0) begin
               outs[0] = '0;
               n = 1;
            end
            outs[n-1].block_done = 1'b1;
         end
         if (n > 0) outs[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) expected_writes.push_back(outs[i]);
      endfunction

      function void flag(string what, byte_write_type want, byte_write_type got);
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display({"%s: exp we=%0b addr=%h data=%h done=%0b last=%0b",
                      " | got we=%0b addr=%h data=%h done=%0b last=%0b"},
                     what, want.write_enable, want.write_address, want.write_data,
                     want.block_done, want.last, got.write_enable, got.write_address,
                     got.write_data, got.block_done, got.last);
      endfunction

      function void check_result(byte_write_type got);
         byte_write_type want;
         results_seen++;
         if (expected_writes.size() == 0) begin
            flag("unexpected item", '0, got);
            return;
         end
         want = expected_writes.pop_front();
         if (got.write_enable !== want.write_enable || got.write_address !== want.write_address
             || got.write_data !== want.write_data || got.block_done !== want.block_done
             || got.last !== want.last)
            flag("wrong item", want, got);
      endfunction

      function int pending();
         return expected_writes.size();
      endfunction

      function void close();
         if (expected_writes.size() != 0) begin
            $display("%0d expected items never arrived", expected_writes.size());
            mismatches += expected_writes.size();
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_on = 1'b1;
   bit   hold_req = 1'b0;
   int   config_writes = 0;
   int unsigned cycle_count = 0;
   reassembly_scoreboard sb = new();

   btr_req_if req_ch();
   btr_rsp_if rsp_ch();
   btr_csr_if csr_ch();

   block_transfer_reassembler_unit #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random back-pressure bursts, plus one long hold on request
   initial begin
      int stall_left;
      int hold_left;
      byte_write_type got;
      stall_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.write_enable  = rsp_ch.write_enable;
            got.write_address = rsp_ch.write_address;
            got.write_data    = rsp_ch.write_data;
            got.block_done    = rsp_ch.block_done;
            got.last          = rsp_ch.last;
            sb.check_result(got);
         end
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic packet_type make_packet(logic [15:0] cmd, logic [15:0] w1);
      packet_type p;
      p.command = cmd;
      for (int i = 1; i < 7; i++) p.words[i] = 16'($urandom);
      p.words[0] = w1;
      return p;
   endfunction

   function automatic packet_type fill_packet(logic [15:0] cmd, logic [15:0] v);
      packet_type p;
      p.command = cmd;
      for (int i = 0; i < 7; i++) p.words[i] = v;
      return p;
   endfunction

   function automatic logic [15:0] pick_code(logic [15:0] dflt);
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return dflt;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_capacity();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(1, 90));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_packet(packet_type p);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= p.command;
      req_ch.word1   <= p.words[0];
      req_ch.word2   <= p.words[1];
      req_ch.word3   <= p.words[2];
      req_ch.word4   <= p.words[3];
      req_ch.word5   <= p.words[4];
      req_ch.word6   <= p.words[5];
      req_ch.word7   <= p.words[6];
      do @(posedge clock); while (!req_ch.ready);
      sb.note_packet(p);
   endtask

   // waits for every expected item; settle also covers a packet that gives none
   task automatic drain(bit settle);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, value);
      config_writes++;
   endtask

   task automatic set_config(logic [15:0] ic, logic [15:0] cc, logic [15:0] cap);
      write_reg(CSR_INIT_CODE, ic);
      write_reg(CSR_CONT_CODE, cc);
      write_reg(CSR_CAPACITY, cap);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] ic, cc, cap;
      int len, conts, counted;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.command <= '0;
      req_ch.word1   <= '0;
      req_ch.word2   <= '0;
      req_ch.word3   <= '0;
      req_ch.word4   <= '0;
      req_ch.word5   <= '0;
      req_ch.word6   <= '0;
      req_ch.word7   <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= '0;
      csr_ch.data    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray and foreign packets, empty block, short and long blocks, restart
      send_packet(fill_packet(CONT_CODE_RST, 16'hFFFF));
      send_packet(make_packet(16'h1234, 16'($urandom)));
      send_packet(fill_packet(INIT_CODE_RST, 16'h0000));
      send_packet(fill_packet(CONT_CODE_RST, 16'h0000));
      send_packet(make_packet(INIT_CODE_RST, 16'd5));
      send_packet(fill_packet(CONT_CODE_RST, 16'hFFFF));
      send_packet(fill_packet(CONT_CODE_RST, 16'hFFFF));
      send_packet(make_packet(INIT_CODE_RST, 16'd20));
      send_packet(make_packet(CONT_CODE_RST, 16'($urandom)));
      send_packet(make_packet(CONT_CODE_RST, 16'($urandom)));
      send_packet(make_packet(INIT_CODE_RST, 16'd3));
      send_packet(make_packet(INIT_CODE_RST, 16'd28));
      send_packet(make_packet(CONT_CODE_RST, 16'($urandom)));
      send_packet(make_packet(CONT_CODE_RST, 16'($urandom)));
      send_packet(fill_packet(INIT_CODE_RST, 16'hFFFF));
      send_packet(fill_packet(CONT_CODE_RST, 16'hFFFF));
      send_packet(fill_packet(CONT_CODE_RST, 16'h0000));
      drain(1'b1);

      // capacity below length, then raised in mid-block
      write_reg(CSR_SPARE, 16'($urandom));
      set_config(INIT_CODE_RST, CONT_CODE_RST, 16'd4);
      send_packet(make_packet(INIT_CODE_RST, 16'd10));
      send_packet(make_packet(CONT_CODE_RST, 16'($urandom)));
      send_packet(make_packet(CONT_CODE_RST, 16'($urandom)));
      drain(1'b1);
      set_config(INIT_CODE_RST, CONT_CODE_RST, 16'd12);
      send_packet(make_packet(CONT_CODE_RST, 16'($urandom)));
      drain(1'b1);

      // extreme codes with zero capacity
      set_config(16'hFFFF, 16'h0000, 16'h0000);
      send_packet(make_packet(16'hFFFF, 16'd0));
      send_packet(make_packet(16'h0000, 16'($urandom)));
      send_packet(make_packet(16'hFFFF, 16'd5));
      send_packet(make_packet(16'h0000, 16'($urandom)));
      drain(1'b1);

      // same code for both: always an init
      set_config(16'h5A5A, 16'h5A5A, 16'hFFFF);
      send_packet(make_packet(16'h5A5A, 16'd2));
      send_packet(make_packet(16'h5A5A, 16'($urandom)));
      drain(1'b1);

      len = 0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         ic  = pick_code(INIT_CODE_RST);
         cc  = pick_code(CONT_CODE_RST);
         cap = pick_capacity();
         if ($urandom_range(0, 7) == 0) cc = ic;
         else if (cc == ic) cc = ~ic;
         if (phase == 2) cap = 16'hFFFF;
         if (phase == NUM_PHASES - 1) idle_on = 1'b0;
         set_config(ic, cc, cap);
         counted = 0;
         if (phase == 2) begin
            // hold the result side while the packet side keeps pushing
            hold_req = 1'b1;
            send_packet(make_packet(ic, 16'd300));
            for (int i = 0; i < 8; i++) send_packet(make_packet(cc, 16'($urandom)));
            counted += 9;
         end
         while (counted < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
               if ($urandom_range(0, 5) != 0) begin
                  len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                                    : int'($urandom_range(0, 70));
                  send_packet(make_packet(ic, 16'(len)));
                  counted++;
               end
               conts = (len + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES + $urandom_range(0, 1);
               if (conts > 6) conts = 6;
               for (int i = 0; i < conts; i++) begin
                  if ($urandom_range(0, 9) == 0)
                     send_packet(make_packet(16'($urandom), 16'($urandom)));
                  send_packet(make_packet(cc, 16'($urandom)));
                  counted++;
               end
            end else begin
               send_packet(make_packet(16'($urandom), 16'($urandom)));
            end
            if ($urandom_range(0, 39) == 0) drain(1'b0);
         end
         drain(1'b1);
      end

      sb.close();
      $display("Run covered %0d packets, %0d blocks completed, %0d items checked,",
               sb.packets_seen, sb.blocks_done, sb.results_seen);
      $display("with %0d register writes over %0d random settings plus directed ones.",
               config_writes, NUM_PHASES);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
